// ===== design/tw_pkg.sv =====
`timescale 1ns / 1ps

package tw_pkg;

  localparam int unsigned TW = 48;
  localparam logic [TW-1:0] TIME_MAX = '1;

  typedef logic [TW-1:0] time_t;

  typedef enum logic [1:0] {
    CMD_TRIGGER = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_STOP    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CREATED  = 3'd0,
    ST_MERGED   = 3'd1,
    ST_DUP      = 3'd2,
    ST_STOPPED  = 3'd3,
    ST_INVALID  = 3'd4,
    ST_CONFLICT = 3'd5,
    ST_WFULL    = 3'd6,
    ST_TFULL    = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    CFG_PRE    = 3'd0,
    CFG_POST   = 3'd1,
    CFG_GAP    = 3'd2,
    CFG_SPAN   = 3'd3,
    CFG_WLIMIT = 3'd4,
    CFG_CMASK  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] source_tag;
    logic [31:0] content_tag;
    logic [1:0]  camera_index;
    logic        well_formed;
    time_t       event_time;
    time_t       wall_time;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [15:0] window_tag;
    logic [31:0] window_version;
    time_t       window_start;
    time_t       window_end;
    time_t       deadline;
    time_t       display_time;
    logic [4:0]  trigger_count;
    logic        truncated;
    logic        closed_early;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] pre;
    logic [31:0] post;
    logic [31:0] gap;
    logic [31:0] span;
    logic [2:0]  wlimit;
    logic [3:0]  cmask;
  } cfg_t;

  typedef struct packed {
    time_t       start_t;
    time_t       end_t;
    time_t       early_t;
    time_t       late_t;
    time_t       hard_t;
    time_t       dead_t;
    time_t       disp_t;
    logic [15:0] tag;
    logic [31:0] version;
    logic        trunc;
  } slot_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] content;
  } entry_t;

  typedef struct packed {
    logic req;
    out_t word;
  } emit_t;

  function automatic time_t add_sat(time_t t, logic [31:0] d);
    logic [TW:0] s;
    s = {1'b0, t} + {{(TW - 31){1'b0}}, d};
    return s[TW] ? TIME_MAX : s[TW-1:0];
  endfunction

  function automatic time_t sub_sat(time_t t, logic [31:0] d);
    time_t dx;
    dx = {{(TW - 32){1'b0}}, d};
    return (t < dx) ? '0 : t - dx;
  endfunction

  function automatic time_t tmin(time_t a, time_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic time_t tmax(time_t a, time_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== design/tw_ram.sv =====
`timescale 1ns / 1ps

module tw_ram #(
  parameter int W = 48,
  parameter int D = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  waddr_i,
  input  logic [W-1:0]                          wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  raddr_i,
  output logic [W-1:0]                          rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/tw_core.sv =====
`timescale 1ns / 1ps

module tw_core #(
  parameter int WS   = 4,
  parameter int TPW  = 16,
  parameter int CAMS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tw_pkg::in_t   in_data_i,
  input  tw_pkg::cfg_t  cfg_i,
  output tw_pkg::emit_t emit_o,
  input  logic          emit_ok_i
);

  import tw_pkg::*;

  localparam int PW = (WS > 1) ? $clog2(WS) : 1;
  localparam int NW = $clog2(WS + 1);
  localparam int CW = $clog2(TPW + 1);
  localparam int PD = WS * TPW;
  localparam int AW = (PD > 1) ? $clog2(PD) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DUP_RD, S_DUP_CMP, S_PREP, S_PREP2, S_MATCH, S_DECIDE, S_TAKE,
    S_MERGE, S_REF1, S_REF2, S_ABS, S_CP_RD, S_CP_WR, S_COMPACT, S_EMIT,
    S_CL_MARK, S_CL_SCAN, S_CL_EMIT, S_CL_COMPACT
  } state_e;

  typedef enum logic [1:0] {
    M_CREATE, M_MERGE, M_ABSORB
  } mode_e;

  function automatic logic [AW-1:0] paddr(logic [PW-1:0] ph, logic [CW-1:0] k);
    return AW'(int'(ph) * TPW + int'(k));
  endfunction

  // Control state
  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  status_e          estat_q, estat_d;
  logic             halted_q, halted_d;
  logic [NW-1:0]    n_q, n_d;
  logic [PW-1:0]    lmap_q [WS];
  logic [PW-1:0]    lmap_d [WS];
  logic [WS-1:0]    used_q, used_d;
  logic [NW-1:0]    i_q, i_d;
  logic [CW-1:0]    k_q, k_d;
  logic [NW-1:0]    p_q, p_d;
  logic             pfound_q, pfound_d;
  logic [WS-1:0]    match_q, match_d;
  logic [WS-1:0]    take_q, take_d;
  logic [WS-1:0]    sel_q, sel_d;
  logic [WS-1:0]    done_q, done_d;
  logic [NW-1:0]    m_q, m_d;
  logic [NW-1:0]    ecnt_q, ecnt_d;
  logic [NW-1:0]    best_q, best_d;
  logic             bfound_q, bfound_d;
  logic             all_q, all_d;
  logic             eslot_q, eslot_d;
  logic [PW-1:0]    eph_q, eph_d;
  logic [PW-1:0]    wph_q, wph_d;
  logic [PW-1:0]    sph_q, sph_d;
  logic [CW-1:0]    scount_q, scount_d;
  logic [CW-1:0]    total_q, total_d;

  // Datapath
  in_t              item_q, item_d;
  time_t            nstart_q, nstart_d;
  time_t            nend_q, nend_d;
  time_t            nendg_q, nendg_d;
  time_t            ustart_q, ustart_d;
  time_t            ulate_q, ulate_d;
  time_t            bstart_q, bstart_d;
  slot_t            w_q, w_d;
  logic [CW-1:0]    wcnt_q, wcnt_d;
  slot_t            slot_q [WS];
  logic [CW-1:0]    scnt_q [WS];
  logic             slot_we;

  // Trigger store
  logic             pool_we;
  logic [AW-1:0]    pool_waddr, pool_raddr;
  entry_t           pool_wdata, pool_rdata;

  tw_ram #(
    .W ($bits(entry_t)),
    .D (PD)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rdata)
  );

  // One slot is looked at per cycle; the state picks which.
  logic [NW-1:0] jm1;
  logic [PW-1:0] rd_ph;
  slot_t         sl;
  logic [CW-1:0] slc;

  assign jm1 = i_q - NW'(1);

  always_comb begin
    unique case (state_q)
      S_DECIDE:  rd_ph = lmap_q[p_q[PW-1:0]];
      S_ABS:     rd_ph = lmap_q[jm1[PW-1:0]];
      S_CL_EMIT: rd_ph = lmap_q[best_q[PW-1:0]];
      S_EMIT:    rd_ph = eph_q;
      default:   rd_ph = lmap_q[i_q[PW-1:0]];
    endcase
  end

  assign sl  = slot_q[rd_ph];
  assign slc = scnt_q[rd_ph];

  logic cam_ok, lim_ok;
  assign cam_ok = (int'(in_data_i.camera_index) < CAMS) &&
                  cfg_i.cmask[in_data_i.camera_index];
  assign lim_ok = int'(n_q) < ((int'(cfg_i.wlimit) > WS) ? WS : int'(cfg_i.wlimit));

  logic [PW-1:0] free_ph;
  always_comb begin
    free_ph = '0;
    for (int f = WS - 1; f >= 0; f--) begin
      if (!used_q[f]) free_ph = PW'(f);
    end
  end

  // Removal of closed or absorbed windows, keeping creation order.
  logic [WS-1:0] drop;
  logic [PW-1:0] cmap [WS];
  logic [NW-1:0] ncomp;
  logic [WS-1:0] freed;

  assign drop = (state_q == S_COMPACT) ? take_q : sel_q;

  always_comb begin
    logic [NW-1:0] wn;
    wn = '0;
    cmap = lmap_q;
    freed = '0;
    for (int r = 0; r < WS; r++) begin
      if (r < int'(n_q)) begin
        if (drop[r]) begin
          freed[lmap_q[r]] = 1'b1;
        end else begin
          cmap[wn[PW-1:0]] = lmap_q[r];
          wn = wn + NW'(1);
        end
      end
    end
    ncomp = wn;
  end

  // Tests on the slot being looked at.
  logic  ov, sp, take_ok;
  time_t cs, cl;
  assign ov = (nstart_q <= add_sat(sl.end_t, cfg_i.gap)) && (sl.start_t <= nendg_q);
  assign sp = tmax(sl.late_t, item_q.event_time) <=
              add_sat(tmin(sl.start_t, nstart_q), cfg_i.span);
  assign cs = tmin(ustart_q, sl.start_t);
  assign cl = tmax(ulate_q, sl.late_t);
  assign take_ok = !(cl > add_sat(cs, cfg_i.span)) && !(slc > (CW'(TPW) - total_q));

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;   mode_d   = mode_q;   estat_d  = estat_q;
    halted_d = halted_q;  n_d      = n_q;      lmap_d   = lmap_q;
    used_d   = used_q;    i_d      = i_q;      k_d      = k_q;
    p_d      = p_q;       pfound_d = pfound_q; match_d  = match_q;
    take_d   = take_q;    sel_d    = sel_q;    done_d   = done_q;
    m_d      = m_q;       ecnt_d   = ecnt_q;   best_d   = best_q;
    bfound_d = bfound_q;  all_d    = all_q;    eslot_d  = eslot_q;
    eph_d    = eph_q;     wph_d    = wph_q;    sph_d    = sph_q;
    scount_d = scount_q;  total_d  = total_q;
    item_d   = item_q;    nstart_d = nstart_q; nend_d   = nend_q;
    nendg_d  = nendg_q;   ustart_d = ustart_q; ulate_d  = ulate_q;
    bstart_d = bstart_q;  w_d      = w_q;      wcnt_d   = wcnt_q;
    slot_we    = 1'b0;
    pool_we    = 1'b0;
    pool_waddr = '0;
    pool_wdata = '0;
    pool_raddr = '0;
    emit_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          i_d    = '0;
          k_d    = '0;
          sel_d  = '0;
          m_d    = '0;
          unique case (in_data_i.command)
            CMD_TRIGGER: begin
              eslot_d = 1'b0;
              if (halted_q) begin
                estat_d = ST_STOPPED;
                state_d = S_EMIT;
              end else if (!cam_ok || !in_data_i.well_formed) begin
                estat_d = ST_INVALID;
                state_d = S_EMIT;
              end else begin
                state_d = S_DUP_RD;
              end
            end
            CMD_ADVANCE: begin
              all_d   = 1'b0;
              state_d = S_CL_MARK;
            end
            CMD_STOP: begin
              if (!halted_q) begin
                halted_d = 1'b1;
                all_d    = 1'b1;
                state_d  = S_CL_MARK;
              end
            end
            default: ;
          endcase
        end
      end

      S_DUP_RD: begin
        if (i_q == n_q) begin
          state_d = S_PREP;
        end else if (k_q == slc) begin
          i_d = i_q + NW'(1);
          k_d = '0;
        end else begin
          pool_raddr = paddr(rd_ph, k_q);
          state_d    = S_DUP_CMP;
        end
      end

      S_DUP_CMP: begin
        if (pool_rdata.tag == item_q.source_tag) begin
          state_d = S_EMIT;
          if (pool_rdata.content != item_q.content_tag) begin
            estat_d = ST_CONFLICT;
            eslot_d = 1'b0;
          end else begin
            estat_d = ST_DUP;
            eslot_d = 1'b1;
            eph_d   = rd_ph;
          end
        end else begin
          k_d     = k_q + CW'(1);
          state_d = S_DUP_RD;
        end
      end

      S_PREP: begin
        nstart_d = sub_sat(item_q.event_time, cfg_i.pre);
        nend_d   = add_sat(item_q.event_time, cfg_i.post);
        state_d  = S_PREP2;
      end

      S_PREP2: begin
        nendg_d  = add_sat(nend_q, cfg_i.gap);
        i_d      = '0;
        pfound_d = 1'b0;
        match_d  = '0;
        state_d  = S_MATCH;
      end

      S_MATCH: begin
        if (i_q == n_q) begin
          state_d = S_DECIDE;
        end else begin
          if (ov && sp) begin
            match_d[i_q[PW-1:0]] = 1'b1;
            if (!pfound_q) begin
              pfound_d = 1'b1;
              p_d      = i_q;
            end
          end
          i_d = i_q + NW'(1);
        end
      end

      S_DECIDE: begin
        eslot_d = 1'b0;
        if (!pfound_q) begin
          if (!lim_ok) begin
            estat_d = ST_WFULL;
            state_d = S_EMIT;
          end else begin
            wph_d              = free_ph;
            pool_we            = 1'b1;
            pool_waddr         = paddr(free_ph, '0);
            pool_wdata.tag     = item_q.source_tag;
            pool_wdata.content = item_q.content_tag;
            w_d.start_t = nstart_q;
            w_d.end_t   = nend_q;
            w_d.early_t = item_q.event_time;
            w_d.late_t  = item_q.event_time;
            w_d.hard_t  = '0;
            w_d.dead_t  = '0;
            w_d.disp_t  = item_q.wall_time;
            w_d.tag     = item_q.source_tag;
            w_d.version = 32'd1;
            w_d.trunc   = 1'b0;
            wcnt_d      = CW'(1);
            mode_d      = M_CREATE;
            state_d     = S_REF1;
          end
        end else if (slc >= CW'(TPW)) begin
          estat_d = ST_TFULL;
          state_d = S_EMIT;
        end else begin
          w_d      = sl;
          wcnt_d   = slc;
          wph_d    = rd_ph;
          ustart_d = tmin(sl.start_t, nstart_q);
          ulate_d  = tmax(sl.late_t, item_q.event_time);
          total_d  = slc + CW'(1);
          i_d      = '0;
          take_d   = '0;
          state_d  = S_TAKE;
        end
      end

      S_TAKE: begin
        if (i_q == n_q) begin
          state_d = S_MERGE;
        end else begin
          if ((i_q != p_q) && match_q[i_q[PW-1:0]] && take_ok) begin
            take_d[i_q[PW-1:0]] = 1'b1;
            ustart_d = cs;
            ulate_d  = cl;
            total_d  = total_q + slc;
          end
          i_d = i_q + NW'(1);
        end
      end

      S_MERGE: begin
        w_d.start_t = tmin(w_q.start_t, nstart_q);
        w_d.end_t   = tmax(w_q.end_t, nend_q);
        if (item_q.event_time < w_q.early_t) begin
          w_d.early_t = item_q.event_time;
          w_d.disp_t  = item_q.wall_time;
        end
        w_d.late_t = tmax(w_q.late_t, item_q.event_time);
        pool_we            = 1'b1;
        pool_waddr         = paddr(wph_q, wcnt_q);
        pool_wdata.tag     = item_q.source_tag;
        pool_wdata.content = item_q.content_tag;
        wcnt_d = wcnt_q + CW'(1);
        if (w_q.version != '1) w_d.version = w_q.version + 32'd1;
        mode_d  = M_MERGE;
        state_d = S_REF1;
      end

      S_REF1: begin
        w_d.hard_t = add_sat(w_q.start_t, cfg_i.span);
        if (w_q.end_t > w_d.hard_t) begin
          w_d.end_t = w_d.hard_t;
          w_d.trunc = 1'b1;
        end
        state_d = S_REF2;
      end

      S_REF2: begin
        w_d.dead_t = tmin(add_sat(w_q.end_t, cfg_i.gap), w_q.hard_t);
        slot_we    = 1'b1;
        unique case (mode_q)
          M_CREATE: begin
            lmap_d[n_q[PW-1:0]] = wph_q;
            used_d[wph_q]       = 1'b1;
            n_d     = n_q + NW'(1);
            estat_d = ST_CREATED;
            eslot_d = 1'b1;
            eph_d   = wph_q;
            state_d = S_EMIT;
          end
          M_MERGE: begin
            i_d     = n_q;
            state_d = S_ABS;
          end
          default: begin
            i_d     = jm1;
            state_d = S_ABS;
          end
        endcase
      end

      // Absorb the chosen windows, newest first.
      S_ABS: begin
        if (i_q == '0) begin
          state_d = S_COMPACT;
        end else if (take_q[jm1[PW-1:0]]) begin
          if (sl.early_t < w_q.early_t) w_d.disp_t = sl.disp_t;
          w_d.start_t = tmin(w_q.start_t, sl.start_t);
          w_d.end_t   = tmax(w_q.end_t, sl.end_t);
          w_d.early_t = tmin(w_q.early_t, sl.early_t);
          w_d.late_t  = tmax(w_q.late_t, sl.late_t);
          w_d.trunc   = w_q.trunc | sl.trunc;
          sph_d    = rd_ph;
          scount_d = slc;
          k_d      = '0;
          state_d  = S_CP_RD;
        end else begin
          i_d = jm1;
        end
      end

      S_CP_RD: begin
        if (k_q == scount_q) begin
          if (w_q.version != '1) w_d.version = w_q.version + 32'd1;
          mode_d  = M_ABSORB;
          state_d = S_REF1;
        end else begin
          pool_raddr = paddr(sph_q, k_q);
          state_d    = S_CP_WR;
        end
      end

      S_CP_WR: begin
        if (wcnt_q < CW'(TPW)) begin
          pool_we    = 1'b1;
          pool_waddr = paddr(wph_q, wcnt_q);
          pool_wdata = pool_rdata;
          wcnt_d     = wcnt_q + CW'(1);
        end
        k_d     = k_q + CW'(1);
        state_d = S_CP_RD;
      end

      S_COMPACT: begin
        lmap_d  = cmap;
        n_d     = ncomp;
        used_d  = used_q & ~freed;
        estat_d = ST_MERGED;
        eslot_d = 1'b1;
        eph_d   = wph_q;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        emit_o.req         = 1'b1;
        emit_o.word.kind   = 1'b0;
        emit_o.word.status = estat_q;
        emit_o.word.last   = 1'b1;
        if (eslot_q) begin
          emit_o.word.window_tag     = sl.tag;
          emit_o.word.window_version = sl.version;
          emit_o.word.window_start   = sl.start_t;
          emit_o.word.window_end     = sl.end_t;
          emit_o.word.deadline       = sl.dead_t;
          emit_o.word.display_time   = sl.disp_t;
          emit_o.word.trigger_count  = 5'(slc);
          emit_o.word.truncated      = sl.trunc;
        end
        if (emit_ok_i) state_d = S_IDLE;
      end

      S_CL_MARK: begin
        if (i_q == n_q) begin
          if (m_q == '0) begin
            state_d = S_IDLE;
          end else begin
            i_d      = '0;
            bfound_d = 1'b0;
            done_d   = '0;
            ecnt_d   = '0;
            state_d  = S_CL_SCAN;
          end
        end else begin
          if (all_q || (item_q.event_time > sl.dead_t)) begin
            sel_d[i_q[PW-1:0]] = 1'b1;
            m_d = m_q + NW'(1);
          end
          i_d = i_q + NW'(1);
        end
      end

      // Find the earliest start among the windows still to go out.
      S_CL_SCAN: begin
        if (i_q == n_q) begin
          state_d = S_CL_EMIT;
        end else begin
          if (sel_q[i_q[PW-1:0]] && !done_q[i_q[PW-1:0]] &&
              (!bfound_q || (sl.start_t < bstart_q))) begin
            best_d   = i_q;
            bstart_d = sl.start_t;
            bfound_d = 1'b1;
          end
          i_d = i_q + NW'(1);
        end
      end

      S_CL_EMIT: begin
        emit_o.req                 = 1'b1;
        emit_o.word.kind           = 1'b1;
        emit_o.word.status         = ST_CREATED;
        emit_o.word.window_tag     = sl.tag;
        emit_o.word.window_version = sl.version;
        emit_o.word.window_start   = sl.start_t;
        emit_o.word.window_end     = sl.end_t;
        emit_o.word.deadline       = sl.dead_t;
        emit_o.word.display_time   = sl.disp_t;
        emit_o.word.trigger_count  = 5'(slc);
        emit_o.word.truncated      = sl.trunc;
        emit_o.word.closed_early   = item_q.event_time < sl.dead_t;
        emit_o.word.last           = (ecnt_q + NW'(1)) == m_q;
        if (emit_ok_i) begin
          done_d[best_q[PW-1:0]] = 1'b1;
          ecnt_d = ecnt_q + NW'(1);
          if ((ecnt_q + NW'(1)) == m_q) begin
            state_d = S_CL_COMPACT;
          end else begin
            i_d      = '0;
            bfound_d = 1'b0;
            state_d  = S_CL_SCAN;
          end
        end
      end

      S_CL_COMPACT: begin
        lmap_d  = cmap;
        n_d     = ncomp;
        used_d  = used_q & ~freed;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= M_CREATE;
      estat_q  <= ST_CREATED;
      halted_q <= 1'b0;
      n_q      <= '0;
      for (int s = 0; s < WS; s++) lmap_q[s] <= '0;
      used_q   <= '0;
      i_q      <= '0;
      k_q      <= '0;
      p_q      <= '0;
      pfound_q <= 1'b0;
      match_q  <= '0;
      take_q   <= '0;
      sel_q    <= '0;
      done_q   <= '0;
      m_q      <= '0;
      ecnt_q   <= '0;
      best_q   <= '0;
      bfound_q <= 1'b0;
      all_q    <= 1'b0;
      eslot_q  <= 1'b0;
      eph_q    <= '0;
      wph_q    <= '0;
      sph_q    <= '0;
      scount_q <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      estat_q  <= estat_d;
      halted_q <= halted_d;
      n_q      <= n_d;
      lmap_q   <= lmap_d;
      used_q   <= used_d;
      i_q      <= i_d;
      k_q      <= k_d;
      p_q      <= p_d;
      pfound_q <= pfound_d;
      match_q  <= match_d;
      take_q   <= take_d;
      sel_q    <= sel_d;
      done_q   <= done_d;
      m_q      <= m_d;
      ecnt_q   <= ecnt_d;
      best_q   <= best_d;
      bfound_q <= bfound_d;
      all_q    <= all_d;
      eslot_q  <= eslot_d;
      eph_q    <= eph_d;
      wph_q    <= wph_d;
      sph_q    <= sph_d;
      scount_q <= scount_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    nstart_q <= nstart_d;
    nend_q   <= nend_d;
    nendg_q  <= nendg_d;
    ustart_q <= ustart_d;
    ulate_q  <= ulate_d;
    bstart_q <= bstart_d;
    w_q      <= w_d;
    wcnt_q   <= wcnt_d;
    if (slot_we) begin
      slot_q[wph_q] <= w_d;
      scnt_q[wph_q] <= wcnt_q;
    end
  end

endmodule

// ===== design/trigger_window_merger_top.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Word
// input    | in        | in_valid_i / in_stall_o | tw_pkg::in_t
// output   | out       | out_valid_o / out_stall_i | tw_pkg::out_t
// config   | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One word is handled at a time. A trigger that passes the checks searches the stored trigger
// tags (up to WINDOW_SLOTS * TRIGGERS_PER_WINDOW) and then tests each open window; a merge also
// absorbs the chosen windows and copies their triggers. Reads of the trigger store are
// registered, and they set the bulk of the work.
// Advance and stop check each open window, then emit the closed ones in order of start.
// Reset clears all windows at once; no clearing pass is needed.
// A stalled output holds the block in its emitting step until taken.

module trigger_window_merger_top #(
  parameter int WINDOW_SLOTS        = 4,
  parameter int TRIGGERS_PER_WINDOW = 16,
  parameter int CAMERAS             = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tw_pkg::in_t   in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tw_pkg::out_t  out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);

  import tw_pkg::*;

  cfg_t  cfg_q;
  emit_t emit;
  logic  emit_ok;
  logic  out_valid_q;
  out_t  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre    <= '0;
      cfg_q.post   <= '0;
      cfg_q.gap    <= '0;
      cfg_q.span   <= 32'd1;
      cfg_q.wlimit <= 3'd4;
      cfg_q.cmask  <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRE:    cfg_q.pre    <= cfg_wdata_i;
        CFG_POST:   cfg_q.post   <= cfg_wdata_i;
        CFG_GAP:    cfg_q.gap    <= cfg_wdata_i;
        CFG_SPAN:   cfg_q.span   <= cfg_wdata_i;
        CFG_WLIMIT: cfg_q.wlimit <= cfg_wdata_i[2:0];
        CFG_CMASK:  cfg_q.cmask  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  tw_core #(
    .WS   (WINDOW_SLOTS),
    .TPW  (TRIGGERS_PER_WINDOW),
    .CAMS (CAMERAS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .emit_o     (emit),
    .emit_ok_i  (emit_ok)
  );

  // The output register frees the core as soon as a word is loaded.
  assign emit_ok = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.req && emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.req && emit_ok) out_q <= emit.word;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/tw_checker.sv =====
`timescale 1ns / 1ps

module tw_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_stall_o,
  input tw_pkg::in_t  in_data_i,
  input logic         out_valid_o,
  input logic         out_stall_i,
  input tw_pkg::out_t out_data_o
);

  import tw_pkg::*;

  // A held word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // An accepted trigger always leaves the block busy in the following cycle.
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == CMD_TRIGGER) |=> in_stall_o)
    else $error("trigger accepted without the block going busy");

  a_outcome_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kind |-> out_data_o.last && !out_data_o.closed_early)
    else $error("trigger outcome without last or with closed_early");

  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kind &&
    (out_data_o.status == ST_STOPPED || out_data_o.status == ST_INVALID ||
     out_data_o.status == ST_CONFLICT || out_data_o.status == ST_WFULL ||
     out_data_o.status == ST_TFULL) |-> (out_data_o.trigger_count == '0))
    else $error("rejected trigger carries window fields");

  a_close_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind |-> (out_data_o.status == ST_CREATED) &&
    (out_data_o.trigger_count != '0))
    else $error("closed window word malformed");

endmodule

bind trigger_window_merger_top tw_checker u_tw_checker (.*);

// ===== test/tb_trigger_window_merger_top.sv =====
`timescale 1ns / 1ps

module tb_trigger_window_merger_top;
  import tw_pkg::*;

  localparam int SLOTS = 4;
  localparam int PER_WINDOW = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    in_t     w;
    bit      typed;
    status_e st;
  } plan_row_t;

  logic         clk_i;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  in_t          in_word;
  logic         out_valid;
  logic         out_stall;
  out_t         out_word;
  logic         cfg_we;
  logic [2:0]   cfg_idx;
  logic [31:0]  cfg_wdata;

  trigger_window_merger_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow copy of the merger state.
  logic [31:0] pre_q, post_q, gap_q, span_q;
  logic [2:0]  wlim_q;
  logic [3:0]  cmask_q;
  slot_t       win [SLOTS];
  int unsigned hits [SLOTS];
  bit          live [SLOTS];
  entry_t      pool [SLOTS][PER_WINDOW];
  bit          halted_q;
  out_t        expected_words[$];

  int  err_count;
  int  cycles;
  int  words_seen;
  int  items_sent;
  int  closed_seen;
  int  burst_left;
  bit  typed_on;
  status_e typed_st;
  bit  hold_req;
  time_t cursor;
  int unsigned step_ticks;
  logic [15:0] tag_base;
  plan_row_t plan[$];

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic time_t clamp_add(time_t t, logic [31:0] d);
    logic [TW:0] s;
    s = {1'b0, t} + {17'd0, d};
    return s[TW] ? TIME_MAX : s[TW-1:0];
  endfunction

  function automatic time_t clamp_sub(time_t t, logic [31:0] d);
    time_t dx;
    dx = {16'd0, d};
    return (t < dx) ? '0 : t - dx;
  endfunction

  function automatic time_t tlo(time_t a, time_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic time_t thi(time_t a, time_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic int open_count();
    int n;
    n = 0;
    while (n < SLOTS && live[n]) n++;
    return n;
  endfunction

  function automatic void bump(int s);
    if (win[s].version != 32'hFFFF_FFFF) win[s].version++;
  endfunction

  function automatic void reseal(int s);
    win[s].hard_t = clamp_add(win[s].start_t, span_q);
    if (win[s].end_t > win[s].hard_t) begin
      win[s].end_t = win[s].hard_t;
      win[s].trunc = 1'b1;
    end
    win[s].dead_t = tlo(clamp_add(win[s].end_t, gap_q), win[s].hard_t);
  endfunction

  function automatic void push_word(bit kind, status_e st, int s, bit early, bit fin);
    out_t o;
    o = '0;
    o.kind = kind;
    o.status = st;
    if (s >= 0) begin
      o.window_tag = win[s].tag;
      o.window_version = win[s].version;
      o.window_start = win[s].start_t;
      o.window_end = win[s].end_t;
      o.deadline = win[s].dead_t;
      o.display_time = win[s].disp_t;
      o.trigger_count = hits[s][4:0];
      o.truncated = win[s].trunc;
    end
    o.closed_early = early;
    o.last = fin;
    expected_words = {expected_words, o};
  endfunction

  // Open windows are kept packed from slot 0 in creation order.
  function automatic void squeeze();
    int w;
    w = 0;
    for (int r = 0; r < SLOTS; r++) begin
      if (live[r]) begin
        if (r != w) begin
          live[w] = 1'b1;
          win[w] = win[r];
          hits[w] = hits[r];
          for (int k = 0; k < PER_WINDOW; k++) pool[w][k] = pool[r][k];
        end
        w++;
      end
    end
    for (; w < SLOTS; w++) live[w] = 1'b0;
  endfunction

  function automatic void fold_in(int p, int s);
    if (win[s].early_t < win[p].early_t) win[p].disp_t = win[s].disp_t;
    win[p].start_t = tlo(win[p].start_t, win[s].start_t);
    win[p].end_t = thi(win[p].end_t, win[s].end_t);
    win[p].early_t = tlo(win[p].early_t, win[s].early_t);
    win[p].late_t = thi(win[p].late_t, win[s].late_t);
    win[p].trunc = win[p].trunc | win[s].trunc;
    for (int k = 0; k < hits[s] && k < PER_WINDOW; k++) begin
      if (hits[p] < PER_WINDOW) begin
        pool[p][hits[p]] = pool[s][k];
        hits[p]++;
      end
    end
    bump(p);
    reseal(p);
    live[s] = 1'b0;
  endfunction

  function automatic void handle_trigger(in_t w);
    int n, p;
    bit match[SLOTS];
    bit take[SLOTS];
    bit ov, sp;
    time_t t, ns, ne, us, ul, cs, cl;
    int unsigned total, lim;
    n = open_count();
    t = w.event_time;
    if (halted_q) begin
      push_word(0, ST_STOPPED, -1, 0, 1);
      return;
    end
    if (!cmask_q[w.camera_index] || !w.well_formed) begin
      push_word(0, ST_INVALID, -1, 0, 1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < hits[i] && k < PER_WINDOW; k++) begin
        if (pool[i][k].tag == w.source_tag) begin
          if (pool[i][k].content != w.content_tag) push_word(0, ST_CONFLICT, -1, 0, 1);
          else push_word(0, ST_DUP, i, 0, 1);
          return;
        end
      end
    end
    ns = clamp_sub(t, pre_q);
    ne = clamp_add(t, post_q);
    p = -1;
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = 1'b0;
      take[i] = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      ov = ns <= clamp_add(win[i].end_t, gap_q) && win[i].start_t <= clamp_add(ne, gap_q);
      sp = thi(win[i].late_t, t) <= clamp_add(tlo(win[i].start_t, ns), span_q);
      match[i] = ov && sp;
      if (match[i] && p < 0) p = i;
    end
    if (p < 0) begin
      lim = (wlim_q > SLOTS) ? SLOTS : wlim_q;
      if (n >= lim) begin
        push_word(0, ST_WFULL, -1, 0, 1);
        return;
      end
      win[n] = '0;
      win[n].start_t = ns;
      win[n].end_t = ne;
      win[n].early_t = t;
      win[n].late_t = t;
      win[n].disp_t = w.wall_time;
      win[n].tag = w.source_tag;
      win[n].version = 1;
      hits[n] = 1;
      pool[n][0].tag = w.source_tag;
      pool[n][0].content = w.content_tag;
      reseal(n);
      live[n] = 1'b1;
      push_word(0, ST_CREATED, n, 0, 1);
      return;
    end
    if (hits[p] >= PER_WINDOW) begin
      push_word(0, ST_TFULL, -1, 0, 1);
      return;
    end
    // Other overlapping windows join only while span and trigger limits still hold.
    us = tlo(win[p].start_t, ns);
    ul = thi(win[p].late_t, t);
    total = hits[p] + 1;
    for (int i = 0; i < n; i++) begin
      if (i != p && match[i]) begin
        cs = tlo(us, win[i].start_t);
        cl = thi(ul, win[i].late_t);
        if (!(cl > clamp_add(cs, span_q) || hits[i] > PER_WINDOW - total)) begin
          take[i] = 1'b1;
          us = cs;
          ul = cl;
          total += hits[i];
        end
      end
    end
    win[p].start_t = tlo(win[p].start_t, ns);
    win[p].end_t = thi(win[p].end_t, ne);
    if (t < win[p].early_t) begin
      win[p].early_t = t;
      win[p].disp_t = w.wall_time;
    end
    win[p].late_t = thi(win[p].late_t, t);
    pool[p][hits[p]].tag = w.source_tag;
    pool[p][hits[p]].content = w.content_tag;
    hits[p]++;
    bump(p);
    reseal(p);
    for (int i = n - 1; i >= 0; i--) if (take[i]) fold_in(p, i);
    squeeze();
    push_word(0, ST_MERGED, p, 0, 1);
  endfunction

  function automatic void close_span(time_t now, bit all);
    int n, m, j;
    int order[SLOTS];
    n = open_count();
    m = 0;
    for (int i = 0; i < n; i++) begin
      if (all || now > win[i].dead_t) begin
        j = m;
        while (j > 0 && win[order[j-1]].start_t > win[i].start_t) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        m++;
      end
    end
    for (int k = 0; k < m; k++)
      push_word(1, ST_CREATED, order[k], now < win[order[k]].dead_t, k == m - 1);
    for (int k = 0; k < m; k++) live[order[k]] = 1'b0;
    squeeze();
  endfunction

  function automatic void predict(in_t w);
    case (w.command)
      CMD_TRIGGER: handle_trigger(w);
      CMD_ADVANCE: close_span(w.event_time, 1'b0);
      CMD_STOP: begin
        if (!halted_q) begin
          halted_q = 1'b1;
          close_span(w.event_time, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    case (idx)
      CFG_PRE:    pre_q = value;
      CFG_POST:   post_q = value;
      CFG_GAP:    gap_q = value;
      CFG_SPAN:   span_q = value;
      CFG_WLIMIT: wlim_q = value[2:0];
      CFG_CMASK:  cmask_q = value[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic setup(logic [31:0] pre, logic [31:0] post, logic [31:0] gap,
                       logic [31:0] span, logic [2:0] wlim, logic [3:0] cmask);
    write_reg(CFG_PRE, pre);
    write_reg(CFG_POST, post);
    write_reg(CFG_GAP, gap);
    write_reg(CFG_SPAN, span);
    write_reg(CFG_WLIMIT, {29'd0, wlim});
    write_reg(CFG_CMASK, {28'd0, cmask});
  endtask

  // Sender: bursts of back-to-back words separated by random gaps.
  task automatic send_word(in_t w, bit typed, status_e st);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    in_word = w;
    typed_on = typed;
    typed_st = st;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    burst_left--;
    if (burst_left == 0) in_valid = 1'b0;
    if (w.command != 2'd3) items_sent++;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    burst_left = 0;
    wait (expected_words.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic in_t mk(logic [1:0] cmd, logic [15:0] tag, logic [31:0] content,
                             logic [1:0] cam, bit wf, time_t t, time_t wall);
    in_t w;
    w.command = cmd;
    w.source_tag = tag;
    w.content_tag = content;
    w.camera_index = cam;
    w.well_formed = wf;
    w.event_time = t;
    w.wall_time = wall;
    return w;
  endfunction

  function automatic void add_row(in_t w, bit typed = 0, status_e st = ST_CREATED);
    plan_row_t r;
    r.w = w;
    r.typed = typed;
    r.st = st;
    plan = {plan, r};
  endfunction

  function automatic time_t rand_time();
    return TW'({$urandom, $urandom});
  endfunction

  // Mostly triggers clustered around a moving cursor, so that windows merge.
  function automatic in_t rand_item();
    in_t w;
    int r;
    logic [15:0] tag;
    r = $urandom_range(0, 99);
    w = mk(CMD_TRIGGER, 0, 0, 2'($urandom_range(0, 3)), $urandom_range(0, 9) != 0,
           clamp_add(cursor, $urandom_range(0, step_ticks)), rand_time());
    if (r < 3) begin
      w.command = 2'd3;
      w.source_tag = 16'($urandom);
    end else if (r < 25) begin
      w.command = CMD_ADVANCE;
      w.event_time = cursor;
      cursor = clamp_add(cursor, $urandom_range(0, 3 * step_ticks));
    end else begin
      tag = ($urandom_range(0, 1) == 0) ? 16'(tag_base + $urandom_range(0, 15)) :
                                           16'($urandom);
      w.source_tag = tag;
      w.content_tag = ($urandom_range(0, 9) == 0) ? $urandom : {tag, ~tag} ^ 32'h5A3C_96E1;
      if ($urandom_range(0, 19) == 0) w.event_time = rand_time();
      cursor = clamp_add(cursor, $urandom_range(0, step_ticks / 2));
    end
    return w;
  endfunction

  task automatic run_phase(int count);
    in_t w;
    int done_here;
    done_here = 0;
    while (done_here < count) begin
      w = rand_item();
      send_word(w, 0, ST_CREATED);
      if (w.command != 2'd3) done_here++;
    end
  endtask

  // A word is predicted when the block takes it.
  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall) begin
      predict(in_word);
      if (typed_on && expected_words.size() > 0)
        expected_words[expected_words.size()-1].status = typed_st;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", 64'd1, 64'd0);
      end else begin
        want = expected_words.pop_front();
        if (want.kind) closed_seen++;
        if (out_word.kind != want.kind) report_mismatch("kind", out_word.kind, want.kind);
        if (out_word.status != want.status)
          report_mismatch("status", out_word.status, want.status);
        if (out_word.window_tag != want.window_tag)
          report_mismatch("window_tag", out_word.window_tag, want.window_tag);
        if (out_word.window_version != want.window_version)
          report_mismatch("window_version", out_word.window_version, want.window_version);
        if (out_word.window_start != want.window_start)
          report_mismatch("window_start", out_word.window_start, want.window_start);
        if (out_word.window_end != want.window_end)
          report_mismatch("window_end", out_word.window_end, want.window_end);
        if (out_word.deadline != want.deadline)
          report_mismatch("deadline", out_word.deadline, want.deadline);
        if (out_word.display_time != want.display_time)
          report_mismatch("display_time", out_word.display_time, want.display_time);
        if (out_word.trigger_count != want.trigger_count)
          report_mismatch("trigger_count", out_word.trigger_count, want.trigger_count);
        if (out_word.truncated != want.truncated)
          report_mismatch("truncated", out_word.truncated, want.truncated);
        if (out_word.closed_early != want.closed_early)
          report_mismatch("closed_early", out_word.closed_early, want.closed_early);
        if (out_word.last != want.last) report_mismatch("last", out_word.last, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stall mode changes every stretch, and one long hold-off fills the block.
  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk_i);
        if (hold_req) begin
          out_stall = 1'b1;
          repeat (800) @(negedge clk_i);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 99) < 30);
          default: out_stall = ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_PRE;
    cfg_wdata = '0;
    rst_n = 1'b0;
    err_count = 0;
    cycles = 0;
    words_seen = 0;
    items_sent = 0;
    closed_seen = 0;
    burst_left = 0;
    typed_on = 1'b0;
    typed_st = ST_CREATED;
    hold_req = 1'b0;
    pre_q = '0;
    post_q = '0;
    gap_q = '0;
    span_q = 32'd1;
    wlim_q = 3'd4;
    cmask_q = 4'd1;
    halted_q = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = 1'b0;
      hits[i] = 0;
      win[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Directed checks at the reset settings: span of one tick, camera 0 only.
    add_row(mk(CMD_TRIGGER, 16'd9, 32'd9, 2'd1, 1, 48'd50, 48'd1), 1, ST_INVALID);
    add_row(mk(CMD_TRIGGER, 16'd9, 32'd9, 2'd0, 0, 48'd50, 48'd1), 1, ST_INVALID);
    add_row(mk(CMD_ADVANCE, 0, 0, 0, 0, 48'd0, 0));
    add_row(mk(CMD_TRIGGER, 16'd1, 32'hA, 2'd0, 1, 48'd100, 48'd7));
    add_row(mk(CMD_TRIGGER, 16'd1, 32'hA, 2'd0, 1, 48'd100, 48'd8));
    add_row(mk(CMD_TRIGGER, 16'd1, 32'hB, 2'd0, 1, 48'd100, 48'd8), 1, ST_CONFLICT);
    add_row(mk(CMD_TRIGGER, 16'd2, 32'h2, 2'd0, 1, 48'd101, 48'd3));
    add_row(mk(CMD_TRIGGER, 16'd3, 32'h3, 2'd0, 1, 48'd0, TIME_MAX));
    add_row(mk(CMD_TRIGGER, 16'd4, 32'h4, 2'd0, 1, TIME_MAX, 48'd0));
    add_row(mk(CMD_TRIGGER, 16'd5, 32'h5, 2'd0, 1, 48'd5000, 48'd5));
    add_row(mk(CMD_TRIGGER, 16'd6, 32'h6, 2'd0, 1, 48'd9000, 48'd6), 1, ST_WFULL);
    add_row(mk(CMD_ADVANCE, 0, 0, 0, 0, TIME_MAX, 0));
    add_row(mk(CMD_TRIGGER, 16'hFFFF, 32'hFFFF_FFFF, 2'd0, 1, 48'd200, 48'd0));
    add_row(mk(CMD_TRIGGER, 16'd0, 32'd0, 2'd0, 1, 48'd201, TIME_MAX));
    add_row(mk(CMD_ADVANCE, 0, 0, 0, 0, 48'd202, 0));
    add_row(mk(2'd3, 16'h55, 0, 0, 0, 48'd5, 0));
    add_row(mk(CMD_TRIGGER, 16'd7, 32'h7, 2'd3, 1, 48'd300, 48'd0), 1, ST_INVALID);
    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].st);
    settle();

    setup(32'd10, 32'd10, 32'd5, 32'd100, 3'd4, 4'hF);
    cursor = 48'd1000;
    step_ticks = 20;
    tag_base = 16'($urandom);
    run_phase(80);
    settle();

    setup(32'd0, 32'd0, 32'd0, 32'd0, 3'd7, 4'b0101);
    step_ticks = 2;
    tag_base = 16'($urandom);
    run_phase(50);
    settle();

    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd2, 4'hF);
    cursor = TIME_MAX - 48'h2_0000_0000;
    step_ticks = 32'h4000_0000;
    tag_base = 16'($urandom);
    run_phase(50);
    settle();

    setup(32'd50, 32'd30, 32'd200, 32'd2000, 3'd1, 4'b1010);
    cursor = 48'd0;
    step_ticks = 40;
    tag_base = 16'($urandom);
    hold_req = 1'b1;
    run_phase(80);
    settle();

    setup(32'd3, 32'd3, 32'd1, 32'd10, 3'd0, 4'b1000);
    step_ticks = 10;
    run_phase(15);
    settle();

    setup(32'd5, 32'd5, 32'd40, 32'd500, 3'd3, 4'hF);
    cursor = rand_time() >> 1;
    step_ticks = 30;
    tag_base = 16'($urandom);
    run_phase(80);
    settle();

    // Stop closes everything and halts for the rest of the run.
    plan.delete();
    add_row(mk(CMD_STOP, 0, 0, 0, 0, cursor, 0));
    add_row(mk(CMD_STOP, 0, 0, 0, 0, cursor, 0));
    add_row(mk(CMD_TRIGGER, 16'd77, 32'd77, 2'd0, 1, cursor, 0), 1, ST_STOPPED);
    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].st);
    settle();

    $display("Sent %0d words through six register settings and a final stop.", items_sent);
    $display("Checked %0d result words, %0d of them closed windows.", words_seen, closed_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
